// ----- rtl/core/gmps_pkg.sv -----
package gmps_pkg;

  // Largest maze side and the widths that follow from it.
  localparam int unsigned MaxSize    = 32;
  localparam int unsigned IdxW       = $clog2(MaxSize);
  localparam int unsigned SizeW      = IdxW + 1;
  localparam int unsigned StackDepth = 2 * MaxSize - 2;
  localparam int unsigned StackW     = $clog2(StackDepth + 1);

  // Move recorded for one level of the search.
  typedef enum logic {
    MOVE_DOWN,
    MOVE_RIGHT
  } move_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_TEST,
    ST_BACK,
    ST_POP,
    ST_KILL,
    ST_FAIL,
    ST_RP_RD,
    ST_RP_EX
  } state_e;

  // One result beat offered by the search core to the output register.
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [MaxSize-1:0] row_bits;
    logic [IdxW-1:0]    row_index;
    logic               last_row;
  } emit_t;

  // One-hot mask of a column.
  function automatic logic [MaxSize-1:0] col_bit(input logic [IdxW-1:0] col);
    logic [MaxSize-1:0] one;
    one = {{(MaxSize-1){1'b0}}, 1'b1};
    return one << col;
  endfunction

endpackage

// ----- rtl/core/grid_maze_path_search_top.sv -----
// Maze path search by depth-first backtracking.
// Input channel: one beat per maze cell (cell_open_i), row-major, n*n beats per run,
// with n taken from the grid size register (0 reads as 1, above 32 as 32).
// A cell beat is taken whenever in_valid_i is high while the block loads; in_stall_o stays high
// from the last cell until the final result beat has entered the output register.
// The search starts at the top-left corner, tries down before right, and runs on
// one sequencer around a maze row memory and a move stack memory. A forward step
// passes ST_CHECK and ST_TEST, a rejected move goes on to ST_BACK, a down move turns
// into a right move through ST_BACK and ST_POP, and a level unwinds through ST_BACK,
// ST_POP and ST_KILL. Each cell is entered at most twice before it is marked dead.
// Output channel: on success n beats, one path row each (found_o set, last_row_o
// on row n-1), replayed from the move stack; on failure one beat with found_o clear
// and last_row_o set.
// The output register frees the core while a beat waits; out_stall_i only holds
// the sequencer when a further beat is ready. Writing the grid size (only while
// idle) restarts loading at cell 0. Reset leaves the block loading with n = 5
// and needs no clearing pass.
module grid_maze_path_search_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gmps_pkg::SizeW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cell_open_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           found_o,
  output logic [gmps_pkg::MaxSize-1:0]   row_bits_o,
  output logic [gmps_pkg::IdxW-1:0]      row_index_o,
  output logic                           last_row_o
);
  import gmps_pkg::*;

  logic [SizeW-1:0]   grid_size_q;
  emit_t              emit;
  logic               emit_rdy;
  logic               out_valid_q;
  logic               found_q, last_row_q;
  logic [MaxSize-1:0] row_bits_q;
  logic [IdxW-1:0]    row_index_q;

  // Grid size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= SizeW'(5);
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  gmps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cell_open_i (cell_open_i),
    .busy_o      (in_stall_o),
    .cfg_clear_i (cfg_we_i),
    .grid_size_i (grid_size_q),
    .emit_o      (emit),
    .emit_rdy_i  (emit_rdy)
  );

  // The output register takes a new beat when empty or when its beat leaves.
  assign emit_rdy = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid && emit_rdy) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid && emit_rdy) begin
      found_q     <= emit.found;
      row_bits_q  <= emit.row_bits;
      row_index_q <= emit.row_index;
      last_row_q  <= emit.last_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign row_bits_o  = row_bits_q;
  assign row_index_o = row_index_q;
  assign last_row_o  = last_row_q;

endmodule

// ----- rtl/core/gmps_core.sv -----
module gmps_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   cell_open_i,
  output logic                   busy_o,
  input  logic                   cfg_clear_i,
  input  logic [gmps_pkg::SizeW-1:0] grid_size_i,
  output gmps_pkg::emit_t        emit_o,
  input  logic                   emit_rdy_i
);
  import gmps_pkg::*;

  state_e state_q, state_d;

  // Load position and the row being assembled.
  logic [IdxW-1:0]    ld_r_q, ld_r_d, ld_c_q, ld_c_d;
  logic [MaxSize-1:0] row_buf_q, row_buf_d;

  // Search position and depth.
  logic [SizeW-1:0]  cur_r_q, cur_r_d, cur_c_q, cur_c_d;
  logic [StackW-1:0] sp_q, sp_d;

  // Replay of the move stack into row masks.
  logic [IdxW-1:0]    rp_row_q, rp_row_d, rp_col_q, rp_col_d;
  logic [MaxSize-1:0] rp_mask_q, rp_mask_d;
  logic [StackW-1:0]  rp_i_q, rp_i_d;

  // Maze memory, one row per entry; dead cells are cleared in place.
  logic [MaxSize-1:0] maze_mem [MaxSize];
  logic [MaxSize-1:0] maze_rd_q;
  logic               maze_we;
  logic [IdxW-1:0]    maze_waddr;
  logic [MaxSize-1:0] maze_wdata;

  // Move stack memory.
  move_e              stk_mem [StackDepth];
  move_e              stk_rd_q;
  logic               stk_we;
  logic [StackW-1:0]  stk_waddr, stk_raddr;
  move_e              stk_wdata;

  logic [SizeW-1:0] side;
  logic [IdxW-1:0]  side_m1;
  logic             in_acc, ld_last, at_goal, in_bounds, maze_bit;
  logic [MaxSize-1:0] row_next;
  logic [SizeW-1:0]   side_m1_w;

  // Grid size out of range is clamped to 1..MaxSize.
  always_comb begin
    if (grid_size_i == '0) begin
      side = SizeW'(1);
    end else if (grid_size_i > SizeW'(MaxSize)) begin
      side = SizeW'(MaxSize);
    end else begin
      side = grid_size_i;
    end
  end

  assign side_m1_w = side - SizeW'(1);
  assign side_m1   = side_m1_w[IdxW-1:0];

  assign busy_o    = (state_q != ST_LOAD);
  assign in_acc    = in_valid_i && !busy_o;
  assign ld_last   = (ld_r_q == side_m1) && (ld_c_q == side_m1);
  assign at_goal   = (cur_r_q == side_m1_w) && (cur_c_q == side_m1_w);
  assign in_bounds = (cur_r_q < side) && (cur_c_q < side);
  assign maze_bit  = |(maze_rd_q & col_bit(cur_c_q[IdxW-1:0]));
  assign row_next  = cell_open_i ? (row_buf_q | col_bit(ld_c_q))
                                 : (row_buf_q & ~col_bit(ld_c_q));

  // Stack read address: the replay index while replaying, the top entry otherwise.
  assign stk_raddr = (state_q == ST_RP_RD || state_q == ST_RP_EX) ? rp_i_q
                                                                  : sp_q - StackW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (in_acc && ld_last) state_d = ST_CHECK;
      ST_CHECK: begin
        if (at_goal) state_d = ST_RP_RD;
        else if (in_bounds) state_d = ST_TEST;
        else state_d = ST_BACK;
      end
      ST_TEST:  state_d = maze_bit ? ST_CHECK : ST_BACK;
      ST_BACK:  state_d = (sp_q == '0) ? ST_FAIL : ST_POP;
      ST_POP:   state_d = (stk_rd_q == MOVE_DOWN) ? ST_CHECK : ST_KILL;
      ST_KILL:  state_d = ST_BACK;
      ST_FAIL:  if (emit_rdy_i) state_d = ST_LOAD;
      ST_RP_RD: begin
        if (rp_i_q == sp_q) begin
          if (emit_rdy_i) state_d = ST_LOAD;
        end else begin
          state_d = ST_RP_EX;
        end
      end
      ST_RP_EX: begin
        if (stk_rd_q == MOVE_RIGHT || emit_rdy_i) state_d = ST_RP_RD;
      end
      default:  state_d = ST_LOAD;
    endcase
  end

  // Datapath, memory controls and result beats.
  always_comb begin
    ld_r_d     = ld_r_q;
    ld_c_d     = ld_c_q;
    row_buf_d  = row_buf_q;
    cur_r_d    = cur_r_q;
    cur_c_d    = cur_c_q;
    sp_d       = sp_q;
    rp_row_d   = rp_row_q;
    rp_col_d   = rp_col_q;
    rp_mask_d  = rp_mask_q;
    rp_i_d     = rp_i_q;
    maze_we    = 1'b0;
    maze_waddr = ld_r_q;
    maze_wdata = row_next;
    stk_we     = 1'b0;
    stk_waddr  = sp_q;
    stk_wdata  = MOVE_DOWN;
    emit_o     = '0;

    case (state_q)
      ST_LOAD: begin
        if (cfg_clear_i) begin
          ld_r_d = '0;
          ld_c_d = '0;
        end else if (in_acc) begin
          row_buf_d = row_next;
          if (ld_c_q == side_m1) begin
            maze_we = 1'b1;
            ld_c_d  = '0;
            ld_r_d  = ld_r_q + IdxW'(1);
          end else begin
            ld_c_d = ld_c_q + IdxW'(1);
          end
          if (ld_last) begin
            ld_r_d  = '0;
            cur_r_d = '0;
            cur_c_d = '0;
            sp_d    = '0;
          end
        end
      end
      ST_CHECK: begin
        if (at_goal) begin
          rp_row_d  = '0;
          rp_col_d  = '0;
          rp_mask_d = col_bit('0);
          rp_i_d    = '0;
        end
      end
      ST_TEST: begin
        // Open cell: take the down move first.
        if (maze_bit) begin
          stk_we  = 1'b1;
          stk_waddr = sp_q;
          stk_wdata = MOVE_DOWN;
          sp_d    = sp_q + StackW'(1);
          cur_r_d = cur_r_q + SizeW'(1);
        end
      end
      ST_POP: begin
        if (stk_rd_q == MOVE_DOWN) begin
          // Down failed: try right from the parent.
          stk_we    = 1'b1;
          stk_waddr = sp_q - StackW'(1);
          stk_wdata = MOVE_RIGHT;
          cur_r_d   = cur_r_q - SizeW'(1);
          cur_c_d   = cur_c_q + SizeW'(1);
        end else begin
          cur_c_d = cur_c_q - SizeW'(1);
          sp_d    = sp_q - StackW'(1);
        end
      end
      ST_KILL: begin
        // Both moves failed from this cell: block it for the rest of the run.
        maze_we    = 1'b1;
        maze_waddr = cur_r_q[IdxW-1:0];
        maze_wdata = maze_rd_q & ~col_bit(cur_c_q[IdxW-1:0]);
      end
      ST_FAIL: begin
        emit_o.valid    = 1'b1;
        emit_o.last_row = 1'b1;
      end
      ST_RP_RD: begin
        if (rp_i_q == sp_q) begin
          emit_o.valid     = 1'b1;
          emit_o.found     = 1'b1;
          emit_o.row_bits  = rp_mask_q;
          emit_o.row_index = rp_row_q;
          emit_o.last_row  = 1'b1;
        end
      end
      ST_RP_EX: begin
        if (stk_rd_q == MOVE_DOWN) begin
          emit_o.valid     = 1'b1;
          emit_o.found     = 1'b1;
          emit_o.row_bits  = rp_mask_q;
          emit_o.row_index = rp_row_q;
          if (emit_rdy_i) begin
            rp_row_d  = rp_row_q + IdxW'(1);
            rp_mask_d = col_bit(rp_col_q);
            rp_i_d    = rp_i_q + StackW'(1);
          end
        end else begin
          rp_col_d  = rp_col_q + IdxW'(1);
          rp_mask_d = rp_mask_q | col_bit(rp_col_q + IdxW'(1));
          rp_i_d    = rp_i_q + StackW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ld_r_q  <= '0;
      ld_c_q  <= '0;
      cur_r_q <= '0;
      cur_c_q <= '0;
      sp_q    <= '0;
      rp_i_q  <= '0;
    end else begin
      state_q <= state_d;
      ld_r_q  <= ld_r_d;
      ld_c_q  <= ld_c_d;
      cur_r_q <= cur_r_d;
      cur_c_q <= cur_c_d;
      sp_q    <= sp_d;
      rp_i_q  <= rp_i_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    row_buf_q <= row_buf_d;
    rp_row_q  <= rp_row_d;
    rp_col_q  <= rp_col_d;
    rp_mask_q <= rp_mask_d;
  end

  // Maze memory: one write port, one registered read of the current row.
  always_ff @(posedge clk_i) begin
    if (maze_we) begin
      maze_mem[maze_waddr] <= maze_wdata;
    end
    maze_rd_q <= maze_mem[cur_r_q[IdxW-1:0]];
  end

  // Move stack memory: one write port, one registered read.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import gmps_pkg::*;

  // Cycles to let pass after the last result before touching the size register.
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned RandomCells   = 320;
  localparam int unsigned OversizeCells = 26;

  // One row of the path mask as it leaves the block.
  typedef struct packed {
    logic               found;
    logic [MaxSize-1:0] row_bits;
    logic [IdxW-1:0]    row_index;
    logic               last_row;
  } path_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             cell_open_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             found_o;
  logic [MaxSize-1:0] row_bits_o;
  logic [IdxW-1:0]  row_index_o;
  logic             last_row_o;

  grid_maze_path_search_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cell_open_i (cell_open_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .row_bits_o  (row_bits_o),
    .row_index_o (row_index_o),
    .last_row_o  (last_row_o)
  );

  // Predictor state: the maze as loaded so far and the size register.
  logic [MaxSize-1:0] maze_mem [MaxSize];
  logic [MaxSize-1:0] path_mask [MaxSize];
  logic [SizeW-1:0]   size_reg = SizeW'(5);
  int unsigned        cells_loaded = 0;

  path_row_t   expected_rows [$];
  bit          cell_queue [$];
  int unsigned cells_pushed = 0;
  int unsigned cells_taken  = 0;
  int unsigned rows_checked = 0;
  int unsigned error_count  = 0;
  logic        cell_taken   = 1'b0;

  initial begin
    for (int k = 0; k < MaxSize; k++) begin
      maze_mem[k]  = '0;
      path_mask[k] = '0;
    end
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Side length actually used for a register value.
  function automatic int unsigned side_of(logic [SizeW-1:0] value);
    if (value == 0) return 1;
    if (value > MaxSize) return MaxSize;
    return 32'(value);
  endfunction

  // Depth-first search from the top-left corner, down before right.
  // Fills path_mask and tells whether the bottom-right corner was reached.
  function automatic bit search_maze(int unsigned n);
    logic [MaxSize-1:0] dead [MaxSize];
    move_e       moves [2*MaxSize];
    int unsigned depth;
    int unsigned row;
    int unsigned col;
    for (int k = 0; k < MaxSize; k++) begin
      path_mask[k] = '0;
      dead[k]      = '0;
    end
    depth = 0;
    row   = 0;
    col   = 0;
    forever begin
      if (row == n - 1 && col == n - 1) begin
        path_mask[row][col] = 1'b1;
        return 1'b1;
      end
      if (row < n && col < n && depth < 2 * MaxSize) begin
        if (maze_mem[row][col] && !dead[row][col]) begin
          path_mask[row][col] = 1'b1;
          moves[depth] = MOVE_DOWN;
          depth++;
          row++;
          continue;
        end
      end
      // This cell is a dead end, so unwind to the last untried right move.
      forever begin
        if (depth == 0) return 1'b0;
        if (moves[depth-1] == MOVE_DOWN) begin
          moves[depth-1] = MOVE_RIGHT;
          row--;
          col++;
          break;
        end
        col--;
        path_mask[row & 31][col] = 1'b0;
        dead[row & 31][col]      = 1'b1;
        depth--;
      end
    end
  endfunction

  function automatic void push_row(logic found, logic [MaxSize-1:0] bits, int unsigned idx,
                                   logic last);
    path_row_t row;
    row.found     = found;
    row.row_bits  = bits;
    row.row_index = IdxW'(idx);
    row.last_row  = last;
    expected_rows.push_back(row);
  endfunction

  // Store one accepted cell and, after the last one, predict the search result.
  function automatic void accept_cell(logic open);
    int unsigned n;
    int unsigned row;
    int unsigned col;
    n   = side_of(size_reg);
    row = cells_loaded / n;
    col = cells_loaded % n;
    if (row >= n) begin
      cells_loaded = 0;
      row = 0;
      col = 0;
    end
    maze_mem[row][col] = open;
    cells_loaded++;
    if (cells_loaded < n * n) return;
    cells_loaded = 0;
    if (!search_maze(n)) begin
      push_row(1'b0, '0, 0, 1'b1);
      return;
    end
    for (int k = 0; k < n; k++) push_row(1'b1, path_mask[k], k, k == n - 1);
  endfunction

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Scoreboard: track register writes and cell beats, check every result beat.
  always @(posedge clk_i) begin
    cell_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        size_reg     = cfg_wdata_i;
        cells_loaded = 0;
      end
      if (in_valid_i && !in_stall_o) begin
        accept_cell(cell_open_i);
        cells_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        rows_checked++;
        if (expected_rows.size() == 0) begin
          $error("unexpected result beat: found %b row_index %0d", found_o, row_index_o);
          error_count++;
        end else begin
          path_row_t want;
          want = expected_rows.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %b, got %b", want.found, found_o);
            error_count++;
          end
          if (row_bits_o !== want.row_bits) begin
            $error("row_bits: expected %h, got %h", want.row_bits, row_bits_o);
            error_count++;
          end
          if (row_index_o !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, row_index_o);
            error_count++;
          end
          if (last_row_o !== want.last_row) begin
            $error("last_row: expected %b, got %b", want.last_row, last_row_o);
            error_count++;
          end
        end
      end
    end
  end

  // Cell driver: holds each beat until taken, with random gaps between beats.
  int unsigned send_gap = 0;
  int unsigned calm_tx  = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || cell_taken) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (cell_queue.size() != 0) begin
        in_valid_i  <= 1'b1;
        cell_open_i <= cell_queue.pop_front();
        if (calm_tx > 0) calm_tx--;
        else if ($urandom_range(0, 49) == 0) calm_tx = $urandom_range(30, 120);
        else send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus long hold-offs now and then so that
  // the block backs up while the driver keeps offering cells.
  int unsigned stall_left   = 0;
  int unsigned calm_rx      = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 10;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (out_valid_o && in_valid_i && rows_checked >= next_hold_at) begin
      out_stall_i <= 1'b1;
      hold_left = $urandom_range(150, 300);
      next_hold_at += 25;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (calm_rx > 0) calm_rx--;
      else if ($urandom_range(0, 49) == 0) calm_rx = $urandom_range(30, 120);
      else stall_left = pick_gap();
    end
  end

  // Wait until every cell is taken and every result has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cell_queue.size() != 0 || cells_taken != cells_pushed || expected_rows.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_grid_size(logic [SizeW-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Queue cells written in reading order, first cell in the top bit.
  task automatic queue_bits(logic [31:0] bits, int unsigned count);
    for (int k = count - 1; k >= 0; k--) begin
      cell_queue.push_back(bits[k]);
      cells_pushed++;
    end
  endtask

  // Queue a random n by n maze, optionally with a carved down/right path,
  // cut short after the given number of cells.
  task automatic queue_maze(int unsigned n, int unsigned open_pct, bit carve,
                            int unsigned count);
    logic [MaxSize-1:0] grid [MaxSize];
    int unsigned row;
    int unsigned col;
    for (int r = 0; r < MaxSize; r++) begin
      grid[r] = '0;
      for (int c = 0; c < n; c++) grid[r][c] = $urandom_range(0, 99) < open_pct;
    end
    if (carve) begin
      row = 0;
      col = 0;
      grid[0][0] = 1'b1;
      while (!(row == n - 1 && col == n - 1)) begin
        if (row == n - 1 || (col != n - 1 && $urandom_range(0, 1) == 1)) col++;
        else row++;
        grid[row][col] = 1'b1;
      end
    end
    for (int k = 0; k < count; k++) begin
      cell_queue.push_back(grid[k / n][k % n]);
      cells_pushed++;
    end
  endtask

  // Stimulus: directed corner cases, an oversized size value, then random runs.
  initial begin
    int unsigned random_cells;
    int unsigned n;
    int unsigned roll;
    int unsigned cap;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // One by one maze succeeds whether the cell is open or blocked.
    write_grid_size(SizeW'(1));
    queue_bits(32'b0, 1);
    queue_bits(32'b1, 1);
    // A size of zero behaves as one.
    write_grid_size(SizeW'(0));
    queue_bits(32'b1, 1);
    // Blocked start fails; a blocked corner is still reached.
    write_grid_size(SizeW'(2));
    queue_bits(32'b0111, 4);
    queue_bits(32'b1010, 4);
    // A partial load is dropped by a size write; then a maze that backtracks.
    write_grid_size(SizeW'(3));
    queue_bits(32'b1010, 4);
    write_grid_size(SizeW'(3));
    queue_bits(32'b111_101_011, 9);

    // An oversized register value reads as the full size, so these cells give no
    // result and the partial load is dropped by the next size write.
    write_grid_size(SizeW'(63));
    queue_maze(MaxSize, 70, 1'b0, OversizeCells);

    // Random runs, mostly small; a few end in a dropped partial load.
    random_cells = 0;
    while (random_cells < RandomCells) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) n = 1;
      else if (roll < 75) n = $urandom_range(2, 6);
      else if (roll < 95) n = $urandom_range(7, 12);
      else n = $urandom_range(13, 16);
      // Keep the total close to the cell budget.
      while (n > 1 && random_cells + n * n > RandomCells) n--;
      write_grid_size(SizeW'(n));
      repeat ($urandom_range(1, 4)) begin
        if (random_cells + n * n <= RandomCells) begin
          queue_maze(n, $urandom_range(45, 95), $urandom_range(0, 1), n * n);
          random_cells += n * n;
        end
      end
      cap = RandomCells - random_cells;
      if (cap > n * n - 1) cap = n * n - 1;
      if (n > 1 && cap > 0 && $urandom_range(0, 9) == 0) begin
        roll = $urandom_range(1, cap);
        queue_maze(n, 70, 1'b0, roll);
        random_cells += roll;
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- grid_maze_path_search_top.f -----
rtl/core/gmps_pkg.sv
rtl/core/gmps_core.sv
rtl/core/grid_maze_path_search_top.sv
sim/testbench.sv
